### rtl/core/lcsr_pkg.sv
// Shared types and constants for the load cell serial reader with tare.
package lcsr_pkg;

  localparam int DATA_BITS    = 24;
  localparam int EXTRA_PULSES = 1;
  localparam int TOTAL_HALF   = 2 * (DATA_BITS + EXTRA_PULSES);
  localparam int TC_W         = $clog2(TOTAL_HALF + 1);
  localparam int DIV_W        = 24;
  localparam int FRAC_BITS    = 8;
  localparam int DVD_W        = DATA_BITS + FRAC_BITS;
  localparam int DCNT_W       = $clog2(DVD_W);
  localparam int WEIGHT_W     = 16;
  localparam int FUNC_W       = 2;

  localparam logic [DIV_W-1:0] SCALE_RESET = DIV_W'(256);

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TARE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MEAS  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WAIT  = 3'b010,
    PH_SHIFT = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              din;
  } in_item_t;

  typedef struct packed {
    logic                sck;
    logic                busy_res;
    logic                done_res;
    logic                tare_set;
    logic [WEIGHT_W-1:0] weight;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic div_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_stat_t;

endpackage

### rtl/core/lcsr_if.sv
// Handshake channel interfaces for items, results and the configuration write.
interface lcsr_in_if;
  logic               valid;
  logic               ready;
  lcsr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lcsr_out_if;
  logic                valid;
  logic                ready;
  lcsr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lcsr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lcsr_pkg::DIV_W-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/lcsr_ctrl.sv
// Controller state machine: sequences accept, divide and result hand-off.
module lcsr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lcsr_pkg::dp_stat_t   stat_i,
  output lcsr_pkg::ctrl_cmd_t  cmd_o
);

  lcsr_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o.step     = 1'b0;
    cmd_o.div_step = 1'b0;
    case (state_q)
      lcsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          state_d    = stat_i.need_div ? lcsr_pkg::ST_DIV : lcsr_pkg::ST_OUT;
        end
      end
      lcsr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = lcsr_pkg::ST_OUT;
        end
      end
      lcsr_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = lcsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/lcsr_dp.sv
// Datapath: tick sequencing, shift register, tare store and serial divider.
module lcsr_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lcsr_pkg::ctrl_cmd_t            cmd_i,
  output lcsr_pkg::dp_stat_t             stat_o,
  input  lcsr_pkg::in_item_t             item_i,
  input  logic                           cfg_we_i,
  input  logic [lcsr_pkg::DIV_W-1:0]     cfg_data_i,
  output lcsr_pkg::out_item_t            res_o
);

  localparam logic [lcsr_pkg::TC_W-1:0] TOTAL_HALF_C =
    lcsr_pkg::TC_W'(lcsr_pkg::TOTAL_HALF);
  localparam logic [lcsr_pkg::TC_W-2:0] BIT_LIMIT =
    (lcsr_pkg::TC_W-1)'(lcsr_pkg::DATA_BITS);
  localparam logic [lcsr_pkg::DATA_BITS-1:0] TOP_BIT =
    {1'b1, {(lcsr_pkg::DATA_BITS-1){1'b0}}};
  localparam logic [lcsr_pkg::DCNT_W-1:0] DCNT_LOAD =
    lcsr_pkg::DCNT_W'(lcsr_pkg::DVD_W - 1);

  lcsr_pkg::phase_e                    phase_q, phase_d;
  logic [lcsr_pkg::TC_W-1:0]           tick_q, tick_d;
  logic [lcsr_pkg::DATA_BITS-1:0]      shift_q, shift_d;
  logic [lcsr_pkg::DATA_BITS-1:0]      tare_q, tare_d;
  logic                                is_tare_q, is_tare_d;
  logic [lcsr_pkg::DIV_W-1:0]          scale_q;
  lcsr_pkg::out_item_t                 res_q, step_res;
  logic                                need_div;
  logic [lcsr_pkg::DATA_BITS-1:0]      word;

  logic [lcsr_pkg::DVD_W-1:0]          quo_q, quo_d;
  logic [lcsr_pkg::DIV_W-1:0]          rem_q, rem_d;
  logic [lcsr_pkg::DCNT_W-1:0]         dcnt_q;
  logic [lcsr_pkg::DIV_W-1:0]          divisor;
  logic [lcsr_pkg::DIV_W:0]            rem_sh;
  logic [lcsr_pkg::DIV_W:0]            rem_sub;
  logic                                rem_ge;

  // Per-tick behaviour of the readout sequencer
  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    shift_d   = shift_q;
    tare_d    = tare_q;
    is_tare_d = is_tare_q;
    step_res  = '0;
    need_div  = 1'b0;
    word      = '0;

    if (phase_d == lcsr_pkg::PH_IDLE &&
        (item_i.func == lcsr_pkg::FUNC_TARE || item_i.func == lcsr_pkg::FUNC_MEAS)) begin
      phase_d   = lcsr_pkg::PH_WAIT;
      is_tare_d = (item_i.func == lcsr_pkg::FUNC_TARE);
      shift_d   = '0;
      tick_d    = '0;
    end

    case (phase_d)
      lcsr_pkg::PH_WAIT: begin
        step_res.busy_res = 1'b1;
        if (!item_i.din) begin
          phase_d = lcsr_pkg::PH_SHIFT;
          tick_d  = '0;
          shift_d = '0;
        end
      end
      lcsr_pkg::PH_SHIFT: begin
        step_res.busy_res = 1'b1;
        if (!tick_d[0]) begin
          step_res.sck = 1'b1;
        end else if (tick_d[lcsr_pkg::TC_W-1:1] < BIT_LIMIT) begin
          shift_d = {shift_d[lcsr_pkg::DATA_BITS-2:0], item_i.din};
        end
        tick_d = tick_d + 1'b1;
        if (tick_d >= TOTAL_HALF_C) begin
          word              = shift_d ^ TOP_BIT;
          step_res.done_res = 1'b1;
          if (is_tare_d) begin
            tare_d            = word;
            step_res.tare_set = 1'b1;
          end else begin
            need_div = (word > tare_q);
          end
          phase_d = lcsr_pkg::PH_IDLE;
          tick_d  = '0;
        end
      end
      default: begin
        phase_d = lcsr_pkg::PH_IDLE;
      end
    endcase
  end

  // One restoring division step per cycle; a zero divisor counts as one
  assign divisor = (scale_q == '0) ? lcsr_pkg::DIV_W'(1) : scale_q;
  assign rem_sh  = {rem_q, quo_q[lcsr_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign rem_ge  = (rem_sh >= {1'b0, divisor});
  assign rem_d   = rem_ge ? rem_sub[lcsr_pkg::DIV_W-1:0] : rem_sh[lcsr_pkg::DIV_W-1:0];
  assign quo_d   = {quo_q[lcsr_pkg::DVD_W-2:0], rem_ge};

  assign stat_o.need_div = need_div;
  assign stat_o.div_last = (dcnt_q == '0);
  assign res_o           = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= lcsr_pkg::PH_IDLE;
      tick_q    <= '0;
      shift_q   <= '0;
      tare_q    <= '0;
      is_tare_q <= 1'b0;
      scale_q   <= lcsr_pkg::SCALE_RESET;
      dcnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_data_i;
      end
      if (cmd_i.step) begin
        phase_q   <= phase_d;
        tick_q    <= tick_d;
        shift_q   <= shift_d;
        tare_q    <= tare_d;
        is_tare_q <= is_tare_d;
        dcnt_q    <= DCNT_LOAD;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
    end
  end

  // Result and divider payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      res_q <= step_res;
      quo_q <= {word - tare_q, {lcsr_pkg::FRAC_BITS{1'b0}}};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      if (dcnt_q == '0) begin
        res_q.weight <= quo_d[lcsr_pkg::WEIGHT_W-1:0];
      end
    end
  end

endmodule

### rtl/core/load_cell_serial_reader_with_tare.sv
// Top level of the load cell serial reader with tare.
// Each input item is one bit tick of the converter link: a command (plain tick, start
// tare, start measure) and the sampled data line level. Every item gives exactly one
// result item holding the clock level to drive for that tick, busy and done flags, a
// tare flag and, on the finishing tick of a measure run, the net weight
// ((word - tare) * 256 / scale_divisor, truncated, low 16 bits; zero when the word does
// not exceed the tare). A start waits for the data line to go low, then runs 24 data
// pulses (high tick, low tick, sampled on the low tick) and one extra pulse for gain 128.
// Sequence: an item is accepted, then the registered result is offered; on the finishing
// tick of a measure run that needs a quotient, the restoring divider runs in between and
// resolves one quotient bit per cycle. The next item is taken once the result has been
// handed over. Write scale_divisor only while no item is in flight; the configuration
// channel is always ready.
module load_cell_serial_reader_with_tare (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcsr_in_if.sink     in_if,
  lcsr_out_if.source  out_if,
  lcsr_cfg_if.sink    cfg_if
);

  lcsr_pkg::ctrl_cmd_t cmd;
  lcsr_pkg::dp_stat_t  stat;

  // Configuration writes land directly in the scale register
  assign cfg_if.ready = 1'b1;

  lcsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the result in the datapath output register until it is taken
  lcsr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .item_i     (in_if.data),
    .cfg_we_i   (cfg_if.valid),
    .cfg_data_i (cfg_if.data),
    .res_o      (out_if.data)
  );

endmodule
